>>> design/assert_macros.svh
// Assertion macros shared by the scan sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/adcrr_pkg.sv
// Shared types, constants and helpers for the ADC round-robin scan sequencer.
// No dependencies.
`timescale 1ns / 1ps
package adcrr_pkg;

   // Sizing
   localparam int MAX_SLOTS    = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int CHANNEL_BITS = 5;
   localparam int SLOT_BITS    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int USED_BITS    = $clog2(MAX_SLOTS + 1);
   localparam int COUNT_BITS   = 4;
   localparam int LIST_BITS    = 40;
   localparam int TICK_BITS    = 8;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 40;

   localparam logic [TICK_BITS-1:0] TICKS_RESET = TICK_BITS'(50);
   localparam logic [TICK_BITS-1:0] TICKS_MAX   = {TICK_BITS{1'b1}};

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CHANNEL_SLOTS = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ACQUIRE_TICKS = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CONV_TIMEOUT  = 2'd3;

   // Configuration as seen by the controller and datapath
   typedef struct packed {
      logic [COUNT_BITS-1:0] channel_count;
      logic [LIST_BITS-1:0]  channel_slots;
      logic [TICK_BITS-1:0]  acquire_ticks;
      logic [TICK_BITS-1:0]  convert_timeout_ticks;
   } cfg_type;

   // Controller -> datapath
   typedef struct packed {
      logic                 store_en;
      logic [SLOT_BITS-1:0] store_idx;
      logic                 active;
      logic                 acquiring;
      logic                 start;
      logic [SLOT_BITS-1:0] sel_idx;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic tick;
      logic conv_done;
   } status_type;

   // Counts above the slot capacity act as the full capacity
   function automatic logic [USED_BITS-1:0] used_slots(input logic [COUNT_BITS-1:0] cnt);
      logic [USED_BITS-1:0] res;
      if (32'(cnt) > MAX_SLOTS) res = USED_BITS'(MAX_SLOTS);
      else                      res = USED_BITS'(cnt);
      return res;
   endfunction

   // Analog input number held in one slot of the scan list
   function automatic logic [CHANNEL_BITS-1:0] slot_channel(input logic [LIST_BITS-1:0] list,
                                                           input logic [SLOT_BITS-1:0] idx);
      logic [CHANNEL_BITS-1:0] res;
      res = list[idx*CHANNEL_BITS +: CHANNEL_BITS];
      return res;
   endfunction

endpackage

>>> design/adcrr_req_if.sv
// Tick channel: converter status and lookup request, valid/ready handshake.
// Depends on adcrr_pkg.
`timescale 1ns / 1ps
interface adcrr_req_if;
   import adcrr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    conv_done;
   logic [SAMPLE_BITS-1:0]  conv_data;
   logic [CHANNEL_BITS-1:0] query_channel;

   modport source (output valid, conv_done, conv_data, query_channel, input ready);
   modport sink   (input valid, conv_done, conv_data, query_channel, output ready);
endinterface

>>> design/adcrr_rsp_if.sv
// Result channel: mux and converter controls plus lookup answer, valid/ready handshake.
// Depends on adcrr_pkg.
`timescale 1ns / 1ps
interface adcrr_rsp_if;
   import adcrr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] mux_select;
   logic                    sample_enable;
   logic                    convert_start;
   logic                    query_found;
   logic [SAMPLE_BITS-1:0]  query_value;

   modport source (output valid, mux_select, sample_enable, convert_start, query_found,
                   query_value, input ready);
   modport sink   (input valid, mux_select, sample_enable, convert_start, query_found,
                   query_value, output ready);
endinterface

>>> design/adcrr_csr_if.sv
// Configuration write channel: register index and write data, valid/ready handshake.
// Depends on adcrr_pkg.
`timescale 1ns / 1ps
interface adcrr_csr_if;
   import adcrr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] addr;
   logic [CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

>>> design/adcrr_csr.sv
// Configuration registers of the scan sequencer.
// Depends on adcrr_pkg and adcrr_csr_if.
`timescale 1ns / 1ps
module adcrr_csr (
   input  logic                clock,
   input  logic                reset,
   adcrr_csr_if.sink           csr_chan,
   output adcrr_pkg::cfg_type  cfg
);
   import adcrr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_chan.addr)
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_chan.wdata[COUNT_BITS-1:0];
            CSR_CHANNEL_SLOTS: cfg_in.channel_slots = csr_chan.wdata[LIST_BITS-1:0];
            CSR_ACQUIRE_TICKS: cfg_in.acquire_ticks = csr_chan.wdata[TICK_BITS-1:0];
            CSR_CONV_TIMEOUT:  cfg_in.convert_timeout_ticks = csr_chan.wdata[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count         <= '0;
         cfg_ff.channel_slots         <= '0;
         cfg_ff.acquire_ticks         <= TICKS_RESET;
         cfg_ff.convert_timeout_ticks <= TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> design/adcrr_ctrl.sv
// Scan controller: phase state machine, slot pointer and tick counter.
// Depends on adcrr_pkg.
`timescale 1ns / 1ps
module adcrr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  adcrr_pkg::cfg_type    cfg,
   input  adcrr_pkg::status_type status,
   output adcrr_pkg::cmd_type    cmd
);
   import adcrr_pkg::*;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ACQUIRE = 2'd1;
   localparam logic [1:0] PH_CONVERT = 2'd2;

   logic [1:0]           phase_ff, phase_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [TICK_BITS-1:0] elapsed_ff, elapsed_in;

   logic [USED_BITS-1:0] used;
   logic [TICK_BITS-1:0] bumped;
   logic [USED_BITS-1:0] next_slot;
   logic [SLOT_BITS-1:0] wrap_idx;
   logic                 start;
   logic                 store_en;

   assign used      = used_slots(cfg.channel_count);
   assign bumped    = (elapsed_ff == TICKS_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign next_slot = USED_BITS'(idx_ff) + 1'b1;
   assign wrap_idx  = (next_slot >= used) ? '0 : next_slot[SLOT_BITS-1:0];

   // Next-state logic, advanced once per tick
   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      elapsed_in = elapsed_ff;
      start      = 1'b0;
      store_en   = 1'b0;
      if (status.tick) begin
         if (used == '0) begin
            phase_in   = PH_IDLE;
            idx_in     = '0;
            elapsed_in = '0;
         end else begin
            case (phase_ff)
               PH_ACQUIRE: begin
                  elapsed_in = bumped;
                  if (bumped >= cfg.acquire_ticks) begin
                     start      = 1'b1;
                     phase_in   = PH_CONVERT;
                     elapsed_in = '0;
                  end
               end
               PH_CONVERT: begin
                  if (status.conv_done) begin
                     store_en   = 1'b1;
                     idx_in     = wrap_idx;
                     phase_in   = PH_ACQUIRE;
                     elapsed_in = '0;
                  end else if (bumped >= cfg.convert_timeout_ticks) begin
                     idx_in     = wrap_idx;
                     phase_in   = PH_ACQUIRE;
                     elapsed_in = '0;
                  end else begin
                     elapsed_in = bumped;
                  end
               end
               default: begin
                  phase_in   = PH_ACQUIRE;
                  idx_in     = '0;
                  elapsed_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         idx_ff     <= '0;
         elapsed_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Commands reflect the state after this tick's update; store_idx names the slot before it
   assign cmd.store_en  = store_en;
   assign cmd.store_idx = idx_ff;
   assign cmd.active    = (phase_in != PH_IDLE);
   assign cmd.acquiring = (phase_in == PH_ACQUIRE);
   assign cmd.start     = start;
   assign cmd.sel_idx   = idx_in;
endmodule

>>> design/adcrr_dp.sv
// Datapath: tick handshake, sample store with valid bits, lookup, result register.
// Depends on adcrr_pkg, adcrr_req_if and adcrr_rsp_if.
`timescale 1ns / 1ps
module adcrr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  adcrr_pkg::cfg_type    cfg,
   input  adcrr_pkg::cmd_type    cmd,
   output adcrr_pkg::status_type status,
   adcrr_req_if.sink             req_chan,
   adcrr_rsp_if.source           rsp_chan
);
   import adcrr_pkg::*;

   logic [SAMPLE_BITS-1:0]  samples_ff [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]    valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_BITS-1:0] mux_ff;
   logic                    sample_en_ff;
   logic                    start_ff;
   logic                    found_ff;
   logic [SAMPLE_BITS-1:0]  value_ff;

   logic                    tick;
   logic [USED_BITS-1:0]    used;
   logic                    hit;
   logic [SAMPLE_BITS-1:0]  hit_value;

   // Take a tick whenever the result register is free or draining
   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign tick = req_chan.valid && req_chan.ready;
   assign status.tick      = tick;
   assign status.conv_done = req_chan.conv_done;

   // Lookup against the store as it stood before this tick; lowest slot wins
   assign used = used_slots(cfg.channel_count);
   always_comb begin
      hit       = 1'b0;
      hit_value = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (USED_BITS'(i) < used) &&
             (slot_channel(cfg.channel_slots, SLOT_BITS'(i)) == req_chan.query_channel)) begin
            hit       = 1'b1;
            hit_value = samples_ff[i];
         end
      end
   end

   // Valid bits set on a completed conversion, never cleared after reset
   always_comb begin
      valid_in = valid_ff;
      if (cmd.store_en) valid_in[cmd.store_idx] = 1'b1;
   end

   assign rsp_valid_in = tick || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample store, no reset
   always_ff @(posedge clock) begin
      if (cmd.store_en) samples_ff[cmd.store_idx] <= req_chan.conv_data;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (tick) begin
         mux_ff       <= cmd.active ? slot_channel(cfg.channel_slots, cmd.sel_idx) : '0;
         sample_en_ff <= cmd.acquiring;
         start_ff     <= cmd.start;
         found_ff     <= hit;
         value_ff     <= hit_value;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mux_select    = mux_ff;
   assign rsp_chan.sample_enable = sample_en_ff;
   assign rsp_chan.convert_start = start_ff;
   assign rsp_chan.query_found   = found_ff;
   assign rsp_chan.query_value   = value_ff;
endmodule

>>> design/adc_round_robin_scan_sequencer.sv
// ADC round-robin scan sequencer, top level.
// A tick's result is registered and offered in the cycle after the tick is taken.
// Throughput: one tick per cycle while results are taken; the result register frees itself in the cycle it drains.
// The lookup is a parallel compare over all slots, done combinationally.
// Reset (synchronous, active high): idle, slot 0, counters and valid bits cleared,
// acquire and timeout registers at 50, other config registers zero; sample store and result fields left as is.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adc_round_robin_scan_sequencer (
   input  logic        clock,
   input  logic        reset,
   adcrr_req_if.sink   req_chan,
   adcrr_rsp_if.source rsp_chan,
   adcrr_csr_if.sink   csr_chan
);
   import adcrr_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   adcrr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   adcrr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .status (status),
      .cmd    (cmd)
   );

   adcrr_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // A conversion never completes on the tick it is started
   `ASSERT_IMPLY(a_no_store_on_start, clock, reset, cmd.store_en, !cmd.start, "store on start tick")

   // A tick with no slots configured reports an idle mux, no sampling and no start
   `ASSERT_NEXT(a_idle_outputs, clock, reset, status.tick && (cfg.channel_count == '0), (rsp_chan.mux_select == '0) && !rsp_chan.sample_enable && !rsp_chan.convert_start, "idle tick not idle")

   // A missed lookup always reports a zero value
   `ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_chan.valid && !rsp_chan.query_found, rsp_chan.query_value == '0, "lookup miss with nonzero value")

   // The start pulse is never shown together with sampling
   `ASSERT_IMPLY(a_start_not_sampling, clock, reset, rsp_chan.valid && rsp_chan.convert_start, !rsp_chan.sample_enable, "start while sampling")
endmodule

>>> bench/tb_adc_round_robin_scan_sequencer.sv
// Self-checking bench for the ADC round-robin scan sequencer: ticks go in, each result
// is checked field by field against a tick-by-tick scan predictor kept in this module.
// Depends on adcrr_pkg and the adcrr_req_if, adcrr_rsp_if and adcrr_csr_if interfaces.
`timescale 1ns / 1ps
module tb_adc_round_robin_scan_sequencer;
   import adcrr_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4;
   localparam int REPORT_LIMIT    = 10;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_ACQUIRE, SCAN_CONVERT} scan_state_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] mux_select;
      logic                    sample_enable;
      logic                    convert_start;
      logic                    query_found;
      logic [SAMPLE_BITS-1:0]  query_value;
   } scan_result_type;

   logic clock;
   logic reset;

   adcrr_req_if req_bus ();
   adcrr_rsp_if rsp_bus ();
   adcrr_csr_if csr_bus ();

   adc_round_robin_scan_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Predictor copy of the registers and the scan state
   logic [COUNT_BITS-1:0]  cfg_count;
   logic [LIST_BITS-1:0]   cfg_list;
   logic [TICK_BITS-1:0]   cfg_acquire;
   logic [TICK_BITS-1:0]   cfg_timeout;
   scan_state_type         scan_state;
   logic [SLOT_BITS-1:0]   scan_slot;
   int                     scan_elapsed;
   logic [SAMPLE_BITS-1:0] slot_sample [MAX_SLOTS];
   logic                   slot_filled [MAX_SLOTS];

   scan_result_type pending_results [$];
   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  hold_request   = 0;
   bit  sender_idles   = 1'b1;
   bit  sink_stalls    = 1'b1;

   function automatic logic [CHANNEL_BITS-1:0] list_channel(input int idx);
      return cfg_list[idx*CHANNEL_BITS +: CHANNEL_BITS];
   endfunction

   function automatic int bump_ticks(input int v);
      return (v >= 255) ? 255 : v + 1;
   endfunction

   // Next slot, wrapping past the active count; a shrunk count wraps straight to 0
   function automatic void move_to_next_slot(input int used);
      int nxt;
      nxt          = int'(scan_slot) + 1;
      scan_slot    = (nxt >= used) ? '0 : SLOT_BITS'(nxt);
      scan_state   = SCAN_ACQUIRE;
      scan_elapsed = 0;
   endfunction

   // One tick of the scan: lookup on the old stores, then the state update
   function automatic scan_result_type scan_tick_result(input logic done,
                                                        input logic [SAMPLE_BITS-1:0] data,
                                                        input logic [CHANNEL_BITS-1:0] query);
      scan_result_type res;
      int              used;
      res  = '0;
      used = (int'(cfg_count) > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_count);
      for (int i = 0; i < used; i++) begin
         if (!res.query_found && slot_filled[i] && list_channel(i) == query) begin
            res.query_found = 1'b1;
            res.query_value = slot_sample[i];
         end
      end
      if (used == 0) begin
         scan_state   = SCAN_IDLE;
         scan_slot    = '0;
         scan_elapsed = 0;
      end else begin
         case (scan_state)
            SCAN_ACQUIRE: begin
               scan_elapsed = bump_ticks(scan_elapsed);
               if (scan_elapsed >= int'(cfg_acquire)) begin
                  // done is dropped on the start tick
                  res.convert_start = 1'b1;
                  scan_state        = SCAN_CONVERT;
                  scan_elapsed      = 0;
               end
            end
            SCAN_CONVERT: begin
               if (done) begin
                  slot_sample[scan_slot] = data;
                  slot_filled[scan_slot] = 1'b1;
                  move_to_next_slot(used);
               end else begin
                  scan_elapsed = bump_ticks(scan_elapsed);
                  if (scan_elapsed >= int'(cfg_timeout)) move_to_next_slot(used);
               end
            end
            default: begin
               scan_state   = SCAN_ACQUIRE;
               scan_slot    = '0;
               scan_elapsed = 0;
            end
         endcase
      end
      res.mux_select    = (scan_state == SCAN_IDLE) ? '0 : list_channel(int'(scan_slot));
      res.sample_enable = (scan_state == SCAN_ACQUIRE);
      return res;
   endfunction

   // Idle lengths: mostly short, a few long
   function automatic int draw_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 75) return int'($urandom_range(1, 3));
      if (r < 95) return int'($urandom_range(4, 12));
      return int'($urandom_range(30, 80));
   endfunction

   function automatic logic [LIST_BITS-1:0] draw_channel_list();
      logic [LIST_BITS-1:0]    lst;
      logic [CHANNEL_BITS-1:0] ch_a, ch_b;
      int                      r;
      r    = int'($urandom_range(0, 99));
      ch_a = CHANNEL_BITS'($urandom_range(0, 31));
      ch_b = CHANNEL_BITS'($urandom_range(0, 31));
      lst  = LIST_BITS'({$urandom, $urandom});
      if (r < 10) lst = '0;
      else if (r < 20) lst = '1;
      else if (r < 45) begin
         // few distinct channels so duplicates exercise first-match order
         for (int i = 0; i < MAX_SLOTS; i++)
            lst[i*CHANNEL_BITS +: CHANNEL_BITS] = $urandom_range(0, 1) ? ch_a : ch_b;
      end
      return lst;
   endfunction

   // Send one tick item; predict its result once it is taken
   task automatic send_tick(input logic done, input logic [SAMPLE_BITS-1:0] data,
                            input logic [CHANNEL_BITS-1:0] query);
      int              gap;
      scan_result_type predicted;
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) < 30) gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.conv_done     <= done;
      req_bus.conv_data     <= data;
      req_bus.query_channel <= query;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted       = scan_tick_result(done, data, query);
      pending_results = {pending_results, predicted};
   endtask

   // Stop offering ticks and let every pending result drain
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.wdata <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_CHANNEL_COUNT: cfg_count   = value[COUNT_BITS-1:0];
         CSR_CHANNEL_SLOTS: cfg_list    = value[LIST_BITS-1:0];
         CSR_ACQUIRE_TICKS: cfg_acquire = value[TICK_BITS-1:0];
         CSR_CONV_TIMEOUT:  cfg_timeout = value[TICK_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_scan(input logic [COUNT_BITS-1:0] count,
                            input logic [LIST_BITS-1:0] lst,
                            input logic [TICK_BITS-1:0] acq,
                            input logic [TICK_BITS-1:0] tmo);
      wait_quiet();
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(count));
      write_reg(CSR_CHANNEL_SLOTS, CSR_DATA_BITS'(lst));
      write_reg(CSR_ACQUIRE_TICKS, CSR_DATA_BITS'(acq));
      write_reg(CSR_CONV_TIMEOUT, CSR_DATA_BITS'(tmo));
   endtask

   // Random ticks; done mostly while converting, a little noise elsewhere
   task automatic send_scan_items(input int n, input int done_pct);
      logic                    done;
      logic [SAMPLE_BITS-1:0]  data;
      logic [CHANNEL_BITS-1:0] query;
      int                      r;
      for (int k = 0; k < n; k++) begin
         if (scan_state == SCAN_CONVERT) done = ($urandom_range(0, 99) < done_pct);
         else done = ($urandom_range(0, 99) < 5);
         r = int'($urandom_range(0, 99));
         if (r < 10) data = '0;
         else if (r < 20) data = '1;
         else data = SAMPLE_BITS'($urandom_range(0, 1023));
         if ($urandom_range(0, 3) != 0)
            query = list_channel(int'($urandom_range(0, MAX_SLOTS - 1)));
         else query = CHANNEL_BITS'($urandom_range(0, 31));
         send_tick(done, data, query);
      end
   endtask

   function automatic logic [COUNT_BITS-1:0] draw_count();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 10) return '0;
      if (r < 20) return COUNT_BITS'(1);
      if (r < 35) return COUNT_BITS'(MAX_SLOTS);
      if (r < 50) return COUNT_BITS'($urandom_range(MAX_SLOTS + 1, 15));
      return COUNT_BITS'($urandom_range(2, MAX_SLOTS - 1));
   endfunction

   function automatic logic [TICK_BITS-1:0] draw_ticks(input int hi);
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 15) return '0;
      if (r < 30) return TICK_BITS'(1);
      if (r < 35) return '1;
      return TICK_BITS'($urandom_range(2, hi));
   endfunction

   // ---------------- tests ----------------

   // Count zero after reset: block stays idle, nothing found
   task automatic test_idle_after_reset();
      send_tick(1'b1, '1, '0);
      send_tick(1'b0, '0, '1);
   endtask

   // Acquire and timeout left at their reset value
   task automatic test_reset_tick_defaults();
      wait_quiet();
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(3));
      write_reg(CSR_CHANNEL_SLOTS, CSR_DATA_BITS'(draw_channel_list()));
      send_scan_items(200, 2);
   endtask

   // Zero ticks, done on the start tick, extreme data, lookup sees old stores
   task automatic test_fast_scan_edges();
      load_scan(COUNT_BITS'(2), LIST_BITS'(31), '0, '0);
      send_tick(1'b0, '0, 5'd31);
      send_tick(1'b1, '1, 5'd31);
      send_tick(1'b1, '1, 5'd31);
      send_tick(1'b0, '0, 5'd31);
      send_tick(1'b0, '0, 5'd0);
      send_tick(1'b0, '0, 5'd0);
      send_tick(1'b1, '0, 5'd0);
      send_tick(1'b0, '0, 5'd31);
      send_tick(1'b1, 10'd512, 5'd0);
      send_tick(1'b0, '0, 5'd0);
   endtask

   // Count above capacity, count shrunk under the current slot, count zero mid-scan
   task automatic test_count_limits();
      logic [LIST_BITS-1:0] lst;
      lst = {25'd0, 5'd0, 5'd31, 5'd7};
      load_scan(4'd15, lst, '1, '1);
      send_tick(1'b0, '0, 5'd31);
      send_tick(1'b0, '0, 5'd7);
      send_tick(1'b0, '0, 5'd0);
      load_scan(COUNT_BITS'(MAX_SLOTS), lst, '0, '0);
      while (!(scan_slot == SLOT_BITS'(3) && scan_state == SCAN_ACQUIRE))
         send_tick(1'b0, '0, 5'd31);
      load_scan(COUNT_BITS'(2), lst, '0, '0);
      repeat (4) send_tick(1'b0, '0, 5'd7);
      load_scan('0, lst, '0, '0);
      send_tick(1'b0, '0, 5'd31);
      send_tick(1'b1, '1, 5'd7);
   endtask

   // Several random settings, extremes among them; valid bits carry across
   task automatic test_random_scan();
      for (int p = 0; p < 10; p++) begin
         load_scan(draw_count(), draw_channel_list(), draw_ticks(8), draw_ticks(10));
         send_scan_items(110, int'($urandom_range(10, 70)));
      end
   endtask

   // Receiver holds off while ticks keep coming, so the input must stall
   task automatic test_output_backpressure();
      load_scan(COUNT_BITS'(MAX_SLOTS), draw_channel_list(), TICK_BITS'(1), TICK_BITS'(3));
      sender_idles = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      send_scan_items(150, 40);
      sender_idles = 1'b1;
   endtask

   // Back-to-back items with the receiver always ready
   task automatic test_steady_stream();
      load_scan(4'd5, draw_channel_list(), TICK_BITS'(2), TICK_BITS'(4));
      sender_idles = 1'b0;
      sink_stalls  = 1'b0;
      send_scan_items(100, 30);
      sender_idles = 1'b1;
      sink_stalls  = 1'b1;
   endtask

   // ---------------- result side ----------------

   // Receiver: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && sink_stalls && $urandom_range(0, 99) < 20) begin
            stall_left = draw_gap();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each taken result with the oldest prediction
   always @(posedge clock) begin : result_check
      scan_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("result item with no tick pending at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (want.mux_select !== rsp_bus.mux_select ||
                want.sample_enable !== rsp_bus.sample_enable ||
                want.convert_start !== rsp_bus.convert_start ||
                want.query_found !== rsp_bus.query_found ||
                want.query_value !== rsp_bus.query_value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch at %0t exp/act: mux %0d/%0d smp %b/%b start %b/%b %s",
                           $realtime, want.mux_select, rsp_bus.mux_select,
                           want.sample_enable, rsp_bus.sample_enable,
                           want.convert_start, rsp_bus.convert_start,
                           $sformatf("found %b/%b value %0d/%0d",
                                     want.query_found, rsp_bus.query_found,
                                     want.query_value, rsp_bus.query_value));
            end
         end
      end
   end

   // Watchdog: too long with no item moving on any channel
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin : run_tests
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.conv_done     = 1'b0;
      req_bus.conv_data     = '0;
      req_bus.query_channel = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.addr          = CSR_CHANNEL_COUNT;
      csr_bus.wdata         = '0;
      // predictor state after reset
      cfg_count    = '0;
      cfg_list     = '0;
      cfg_acquire  = TICKS_RESET;
      cfg_timeout  = TICKS_RESET;
      scan_state   = SCAN_IDLE;
      scan_slot    = '0;
      scan_elapsed = 0;
      for (int i = 0; i < MAX_SLOTS; i++) slot_filled[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_after_reset();
      test_reset_tick_defaults();
      test_fast_scan_edges();
      test_count_limits();
      test_random_scan();
      test_output_backpressure();
      test_steady_stream();

      wait_quiet();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
